/* src/pcis_pkg.sv */
`default_nettype none
package pcis_pkg;

    localparam int MEM_WORDS    = 1024;
    localparam int MEM_AW       = $clog2(MEM_WORDS);
    localparam int REG_COUNT    = 8;
    localparam int RF_AW        = $clog2(REG_COUNT);
    localparam int PAGE_WORDS   = 16;
    localparam int OFF_W        = $clog2(PAGE_WORDS);
    localparam int PAGE_ENTRIES = 16;
    localparam int PG_AW        = $clog2(PAGE_ENTRIES);
    localparam int FRAME_COUNT  = 64;
    localparam int FR_W         = $clog2(FRAME_COUNT);

    localparam logic [1:0] IOP_WMEM  = 2'd0;
    localparam logic [1:0] IOP_WPAGE = 2'd1;
    localparam logic [1:0] IOP_START = 2'd2;
    localparam logic [1:0] IOP_EXEC  = 2'd3;

    localparam logic [4:0] OPC_JMP   = 5'h00;
    localparam logic [4:0] OPC_JMPI  = 5'h01;
    localparam logic [4:0] OPC_JMPIG = 5'h02;
    localparam logic [4:0] OPC_JMPIL = 5'h03;
    localparam logic [4:0] OPC_JMPIE = 5'h04;
    localparam logic [4:0] OPC_TRAP  = 5'h05;
    localparam logic [4:0] OPC_ADDI  = 5'h08;
    localparam logic [4:0] OPC_SUBI  = 5'h09;
    localparam logic [4:0] OPC_ANDI  = 5'h0A;
    localparam logic [4:0] OPC_ORI   = 5'h0B;
    localparam logic [4:0] OPC_LDI   = 5'h0C;
    localparam logic [4:0] OPC_LDD   = 5'h0D;
    localparam logic [4:0] OPC_STD   = 5'h0E;
    localparam logic [4:0] OPC_ADD   = 5'h10;
    localparam logic [4:0] OPC_SUB   = 5'h11;
    localparam logic [4:0] OPC_AND   = 5'h12;
    localparam logic [4:0] OPC_OR    = 5'h13;
    localparam logic [4:0] OPC_LDX   = 5'h14;
    localparam logic [4:0] OPC_STX   = 5'h15;
    localparam logic [4:0] OPC_NOT   = 5'h18;
    localparam logic [4:0] OPC_SHL   = 5'h19;
    localparam logic [4:0] OPC_SHR   = 5'h1A;
    localparam logic [4:0] OPC_SWAP  = 5'h1B;
    localparam logic [4:0] OPC_MULT  = 5'h1C;
    localparam logic [4:0] OPC_STOP  = 5'h1F;

    localparam logic [1:0] MK_NONE = 2'd0;
    localparam logic [1:0] MK_RES  = 2'd1;
    localparam logic [1:0] MK_TRAP = 2'd2;

    typedef struct packed {
        logic        illegal;
        logic        trap_valid;
        logic [31:0] trap_code;
        logic [9:0]  trap_address;
        logic [31:0] trap_content;
        logic        write_valid;
        logic [2:0]  write_reg;
        logic [31:0] write_value;
    } t_result;

endpackage
`default_nettype wire

/* src/paged_cpu_instruction_step.sv */
`default_nettype none
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_op, i_addr, i_data
// output  | o_valid | i_stall | o_pc, o_halted, o_illegal, o_trap_*, o_write_*
// Memory, page and start beats go straight to the done state; an execute beat
// passes fetch, decode and execute, plus a memory state for LDD, LDX and TRAP,
// as fetch and data reads share the one memory port; while stopped, it goes to done.
// After reset the word memory is swept to zero, word by word, with
// o_stall high. A stalled result holds in the output register; a new beat is
// taken while it waits, and the next result waits for it.
module paged_cpu_instruction_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [9:0]  i_addr,
    input  wire logic [31:0] i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [9:0]       o_pc,
    output logic             o_halted,
    output logic             o_illegal,
    output logic             o_trap_valid,
    output logic [31:0]      o_trap_code,
    output logic [9:0]       o_trap_address,
    output logic [31:0]      o_trap_content,
    output logic             o_write_valid,
    output logic [2:0]       o_write_reg,
    output logic [31:0]      o_write_value
);
    import pcis_pkg::*;

    typedef enum logic [6:0] {
        S_CLR   = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_DEC   = 7'b0001000,
        S_EXE   = 7'b0010000,
        S_MEM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [MEM_AW-1:0]       r_clr, n_clr;
    logic [MEM_AW-1:0]       r_pc, n_pc;
    logic                    r_stop, n_stop;
    logic [FR_W-1:0]         r_pt [PAGE_ENTRIES];
    logic                    pt_we;
    logic [PG_AW-1:0]        pt_wa;
    logic [FR_W-1:0]         pt_wd;

    logic [31:0]             mem [MEM_WORDS];
    logic [31:0]             r_mq;
    logic                    mem_we;
    logic [MEM_AW-1:0]       mem_addr;
    logic [31:0]             mem_wd;

    logic [31:0]             rf [REG_COUNT];
    logic [REG_COUNT-1:0]    r_rv;
    logic [31:0]             r_qa, r_qb;
    logic                    r_a_ok, r_b_ok;
    logic                    rf_we;
    logic [RF_AW-1:0]        ra_rd, rb_rd;

    logic [31:0]             r_ins, n_ins;
    t_result                 r_res, n_res;
    logic [1:0]              r_mk, n_mk;
    t_result                 r_out;
    logic [MEM_AW-1:0]       r_opc_pc;
    logic                    r_ov;
    logic                    out_load;

    logic [4:0]              opc;
    logic [31:0]             a, b, imm, res, xl_in, phys32;
    logic [FR_W-1:0]         frame;
    logic [MEM_AW-1:0]       xl_out;
    logic                    wr_a;

    assign opc   = r_ins[31:27];
    assign imm   = {16'd0, r_ins[15:0]};
    assign a     = r_a_ok ? r_qa : 32'd0;
    assign b     = r_b_ok ? r_qb : 32'd0;
    assign ra_rd = r_mq[26:24];
    assign rb_rd = r_mq[23:21];

    assign xl_in  = (opc == OPC_TRAP) ? b : ((opc == OPC_JMP) ? imm : a);
    assign frame  = r_pt[xl_in[OFF_W +: PG_AW]];
    assign phys32 = (32'(frame) << OFF_W) | 32'(xl_in[OFF_W-1:0]);
    assign xl_out = phys32[MEM_AW-1:0];

    assign rf_we    = (r_state == S_DONE) && r_res.write_valid;
    assign out_load = (r_state == S_DONE) && (!r_ov || !i_stall);
    assign o_stall  = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_pc     = r_pc;
        n_stop   = r_stop;
        n_ins    = r_ins;
        n_res    = r_res;
        n_mk     = r_mk;
        mem_we   = 1'b0;
        mem_addr = r_pc;
        mem_wd   = i_data;
        pt_we    = 1'b0;
        pt_wa    = i_addr[PG_AW-1:0];
        pt_wd    = i_data[FR_W-1:0];
        res      = 32'd0;
        wr_a     = 1'b1;
        unique case (r_state)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                mem_wd   = 32'd0;
                n_clr    = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_res   = '0;
                    n_mk    = MK_NONE;
                    n_state = S_DONE;
                    unique case (i_op)
                        IOP_WMEM: begin
                            mem_we   = 1'b1;
                            mem_addr = i_addr[MEM_AW-1:0];
                        end
                        IOP_WPAGE: begin
                            pt_we = (32'(i_addr) < 32'(PAGE_ENTRIES));
                        end
                        IOP_START: begin
                            n_pc   = MEM_AW'(32'(i_addr) & 32'(MEM_WORDS - 1));
                            n_stop = 1'b0;
                        end
                        default: begin
                            if (!r_stop) begin
                                n_state = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                n_ins   = r_mq;
                n_pc    = r_pc + 1'b1;
                n_state = S_EXE;
            end
            S_EXE: begin
                n_state = S_DONE;
                unique case (opc) inside
                    OPC_JMP, OPC_JMPI: begin
                        n_pc = xl_out;
                        wr_a = 1'b0;
                    end
                    OPC_JMPIG: begin
                        if (b != 32'd0 && !b[31]) n_pc = xl_out;
                        wr_a = 1'b0;
                    end
                    OPC_JMPIL: begin
                        if (b[31]) n_pc = xl_out;
                        wr_a = 1'b0;
                    end
                    OPC_JMPIE: begin
                        if (b == 32'd0) n_pc = xl_out;
                        wr_a = 1'b0;
                    end
                    OPC_TRAP: begin
                        wr_a               = 1'b0;
                        n_res.trap_valid   = 1'b1;
                        n_res.trap_code    = a;
                        n_res.trap_address = 10'(32'(xl_out));
                        mem_addr           = b[MEM_AW-1:0];
                        n_mk               = MK_TRAP;
                        n_state            = S_MEM;
                    end
                    OPC_ADDI: res = a + imm;
                    OPC_SUBI: res = a - imm;
                    OPC_ANDI: res = a & imm;
                    OPC_ORI:  res = a | imm;
                    OPC_LDI:  res = imm;
                    OPC_LDD: begin
                        mem_addr = imm[MEM_AW-1:0];
                        n_mk     = MK_RES;
                        n_state  = S_MEM;
                    end
                    OPC_STD: begin
                        mem_we   = 1'b1;
                        mem_addr = imm[MEM_AW-1:0];
                        mem_wd   = a;
                        wr_a     = 1'b0;
                    end
                    OPC_ADD:  res = a + b;
                    OPC_SUB:  res = a - b;
                    OPC_AND:  res = a & b;
                    OPC_OR:   res = a | b;
                    OPC_LDX: begin
                        mem_addr = b[MEM_AW-1:0];
                        n_mk     = MK_RES;
                        n_state  = S_MEM;
                    end
                    OPC_STX: begin
                        mem_we   = 1'b1;
                        mem_addr = a[MEM_AW-1:0];
                        mem_wd   = b;
                        wr_a     = 1'b0;
                    end
                    OPC_NOT:  res = ~a;
                    OPC_SHL:  res = a << 1;
                    OPC_SHR:  res = {a[31], a[31:1]};
                    OPC_SWAP: res = ((a & 32'h0F0F0F0F) << 4) | ((a >> 4) & 32'h0F0F0F0F);
                    OPC_MULT: res = a * b;
                    OPC_STOP: begin
                        n_stop = 1'b1;
                        wr_a   = 1'b0;
                    end
                    default: begin
                        n_res.illegal = 1'b1;
                        wr_a          = 1'b0;
                    end
                endcase
                if (wr_a) begin
                    n_res.write_valid = 1'b1;
                    n_res.write_reg   = r_ins[26:24];
                    n_res.write_value = res;
                end
            end
            S_MEM: begin
                if (r_mk == MK_TRAP) begin
                    n_res.trap_content = r_mq;
                end else begin
                    n_res.write_value = r_mq;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_pc    <= '0;
            r_stop  <= 1'b0;
            r_rv    <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < PAGE_ENTRIES; i++) begin
                r_pt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pc    <= n_pc;
            r_stop  <= n_stop;
            if (pt_we) begin
                r_pt[pt_wa] <= pt_wd;
            end
            if (rf_we) begin
                r_rv[r_res.write_reg] <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins <= n_ins;
        r_res <= n_res;
        r_mk  <= n_mk;
        if (out_load) begin
            r_out    <= r_res;
            r_opc_pc <= r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_mq <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[r_res.write_reg] <= r_res.write_value;
        end
        r_qa   <= rf[ra_rd];
        r_qb   <= rf[rb_rd];
        r_a_ok <= r_rv[ra_rd];
        r_b_ok <= r_rv[rb_rd];
    end

    logic r_halt_out;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_halt_out <= r_stop;
        end
    end

    assign o_valid        = r_ov;
    assign o_pc           = 10'(32'(r_opc_pc));
    assign o_halted       = r_halt_out;
    assign o_illegal      = r_out.illegal;
    assign o_trap_valid   = r_out.trap_valid;
    assign o_trap_code    = r_out.trap_code;
    assign o_trap_address = r_out.trap_address;
    assign o_trap_content = r_out.trap_content;
    assign o_write_valid  = r_out.write_valid;
    assign o_write_reg    = r_out.write_reg;
    assign o_write_value  = r_out.write_value;

endmodule
`default_nettype wire

/* src/pcis_checker.sv */
`default_nettype none
module pcis_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [9:0]  o_pc,
    input wire logic        o_illegal,
    input wire logic        o_trap_valid,
    input wire logic [31:0] o_trap_code,
    input wire logic [31:0] o_trap_content,
    input wire logic        o_write_valid
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("block ready or result shown right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pc))
        else $error("stalled result beat changed");

    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_trap_valid && o_write_valid) && !(o_illegal && o_write_valid)
                    && !(o_illegal && o_trap_valid))
        else $error("result beat reports more than one effect");

    a_trap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_trap_valid |-> o_trap_code == 32'd0 && o_trap_content == 32'd0)
        else $error("trap fields set without trap");

endmodule

bind paged_cpu_instruction_step pcis_checker u_pcis_checker (.*);
`default_nettype wire
